>>> hdl/spqd_pkg.sv
// spqd_pkg: request codes, event codes, config indices and widths for the
// strict priority ready queue dispatcher. Depends on nothing.
package spqd_pkg;
  localparam int ID_W    = 10;
  localparam int TIME_W  = 16;
  localparam int CLASS_W = 2;
  localparam int ENTRY_W = 2 * ID_W + CLASS_W;
  localparam int NUM_Q   = 4;

  localparam logic [2:0] REQ_ENQUEUE  = 3'd0;
  localparam logic [2:0] REQ_DISPATCH = 3'd1;
  localparam logic [2:0] REQ_BLOCK    = 3'd2;
  localparam logic [2:0] REQ_READY    = 3'd3;
  localparam logic [2:0] REQ_QUERY    = 3'd4;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_TSW  = 3'd1;
  localparam logic [2:0] EV_PSW  = 3'd2;
  localparam logic [2:0] EV_IO   = 3'd3;
  localparam logic [2:0] EV_DUE  = 3'd4;
  localparam logic [2:0] EV_DONE = 3'd5;
  localparam logic [2:0] EV_ERR  = 3'd6;

  localparam logic [0:0] CFG_TSW = 1'd0;
  localparam logic [0:0] CFG_PSW = 1'd1;

  typedef logic [ENTRY_W-1:0] entry_t;
endpackage

>>> hdl/spqd_ram.sv
// spqd_ram: generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
module spqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/strict_priority_ready_queue_dispatcher.sv
// strict_priority_ready_queue_dispatcher: top level with sequencer, queue
// pointers and blocked pool scan. Depends on spqd_pkg and spqd_ram.
//
//  channel  | ports                                            | handshake
//  ---------+--------------------------------------------------+-----------------
//  request  | req_type proc_id thread_id prio_class io_time   | start & !busy
//  result   | event_kind out_proc_id out_thread_id event_time | done, one cycle
//           | queue_index                                      |
//  config   | cfg_we cfg_index cfg_data                        | cfg_we
//
// Ready scans the blocked pool one entry per cycle through one RAM read port,
// as does query when every ready queue is empty and the pool is not; a ready
// hit with room in its class queue shifts the entries above it down one place
// to keep the pool compact.
// Reset clears queue pointers, running and pool state; the RAMs need no clear.
// The receiver cannot stall: done pulses once per word and busy drops with it.
module strict_priority_ready_queue_dispatcher
  import spqd_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int BLOCKED_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          req_type,
  input  logic [ID_W-1:0]     proc_id,
  input  logic [ID_W-1:0]     thread_id,
  input  logic [CLASS_W-1:0]  prio_class,
  input  logic [TIME_W-1:0]   io_time,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [TIME_W-1:0]   cfg_data,
  output logic                done,
  output logic [2:0]          event_kind,
  output logic [ID_W-1:0]     out_proc_id,
  output logic [ID_W-1:0]     out_thread_id,
  output logic [TIME_W-1:0]   event_time,
  output logic [CLASS_W-1:0]  queue_index
);
  localparam int QA_W     = $clog2(QUEUE_DEPTH);
  localparam int QC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RS_DEPTH = NUM_Q * (2 ** QA_W);  // one power-of-two slab per class
  localparam int RA_W     = $clog2(RS_DEPTH);
  localparam int BA_W     = $clog2(BLOCKED_DEPTH);
  localparam int BC_W     = $clog2(BLOCKED_DEPTH + 1);
  localparam int BE_W     = ENTRY_W + TIME_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RDWT  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_SHWR  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state;
  logic [2:0]         req;
  logic [ID_W-1:0]    pid, tid;
  logic [CLASS_W-1:0] cls;
  logic [TIME_W-1:0]  io;
  logic [TIME_W-1:0]  tsw_ovh, psw_ovh;

  logic [QA_W-1:0]    qhead [NUM_Q];
  logic [QA_W-1:0]    qtail [NUM_Q];
  logic [QC_W-1:0]    qcount [NUM_Q];
  entry_t             running_entry;
  logic               running_valid;
  logic [BC_W-1:0]    pool_n;   // pool stays compact, so a count suffices
  logic [CLASS_W-1:0] last_queue;

  logic [BC_W-1:0]    idx;      // scan position
  logic [TIME_W-1:0]  best;
  logic               scan_first;

  // ready store RAM
  logic               rs_we;
  logic [RA_W-1:0]    rs_waddr, rs_raddr;
  entry_t             rs_wdata, rs_rdata;
  // blocked pool RAM
  logic               bp_we;
  logic [BA_W-1:0]    bp_waddr, bp_raddr;
  logic [BE_W-1:0]    bp_wdata, bp_rdata;

  spqd_ram #(.WIDTH(ENTRY_W), .DEPTH(RS_DEPTH)) u_ready (
    .clk, .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata)
  );
  spqd_ram #(.WIDTH(BE_W), .DEPTH(BLOCKED_DEPTH)) u_pool (
    .clk, .we(bp_we), .waddr(bp_waddr), .wdata(bp_wdata),
    .raddr(bp_raddr), .rdata(bp_rdata)
  );

  // highest non-empty class, 3 when all empty
  logic [CLASS_W-1:0] sel_q;
  always_comb begin
    priority if (qcount[0] != '0) sel_q = 2'd0;
    else if (qcount[1] != '0)     sel_q = 2'd1;
    else if (qcount[2] != '0)     sel_q = 2'd2;
    else                          sel_q = 2'd3;
  end

  // push target class: request class on enqueue, entry class on ready
  logic [CLASS_W-1:0] push_q;
  entry_t             push_entry;
  entry_t             scan_entry;
  assign scan_entry = bp_rdata[BE_W-1:TIME_W];
  always_comb begin
    if (req == REQ_READY) begin
      push_entry = scan_entry;
    end else begin
      push_entry = {pid, tid, cls};
    end
    push_q = push_entry[CLASS_W-1:0];
  end
  logic push_full;
  assign push_full = (qcount[push_q] == QC_W'(QUEUE_DEPTH));

  // wrapped pointer advance for the push and pop classes
  logic [QA_W-1:0] tail_inc, head_inc;
  assign tail_inc = (qtail[push_q] == QA_W'(QUEUE_DEPTH - 1)) ? '0 :
                    qtail[push_q] + 1'b1;
  assign head_inc = (qhead[sel_q] == QA_W'(QUEUE_DEPTH - 1)) ? '0 :
                    qhead[sel_q] + 1'b1;

  logic scan_hit;
  assign scan_hit = (scan_entry[ENTRY_W-1:ID_W+CLASS_W] == pid) &&
                    (scan_entry[ID_W+CLASS_W-1:CLASS_W] == tid);

  assign busy = (state != S_IDLE);

  // memory ports
  always_comb begin
    rs_we    = 1'b0;
    rs_waddr = {push_q, qtail[push_q]};
    rs_wdata = push_entry;
    rs_raddr = {sel_q, qhead[sel_q]};
    bp_we    = 1'b0;
    bp_waddr = pool_n[BA_W-1:0];
    bp_wdata = {running_entry, io};
    bp_raddr = idx[BA_W-1:0];
    unique case (state)
      S_EXEC: begin
        rs_we = (req == REQ_ENQUEUE) && !push_full;
        bp_we = (req == REQ_BLOCK) && running_valid &&
                (pool_n != BC_W'(BLOCKED_DEPTH));
      end
      S_SCAN: begin
        // bp_rdata holds entry idx-1
        rs_we = (req == REQ_READY) && (BC_W'(idx - 1'b1) < pool_n) &&
                scan_hit && !push_full;
      end
      S_SHIFT: begin
        bp_raddr = BA_W'(idx + 1'b1);
      end
      S_SHWR: begin
        bp_we    = 1'b1;
        bp_waddr = idx[BA_W-1:0];
        bp_wdata = bp_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      tsw_ovh       <= '0;
      psw_ovh       <= '0;
      running_entry <= '0;
      running_valid <= 1'b0;
      pool_n        <= '0;
      last_queue    <= '0;
      for (int q = 0; q < NUM_Q; q++) begin
        qhead[q]  <= '0;
        qtail[q]  <= '0;
        qcount[q] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_TSW) tsw_ovh <= cfg_data;
        else                      psw_ovh <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req <= req_type; pid <= proc_id; tid <= thread_id;
            cls <= prio_class; io <= io_time;
            idx <= '0; scan_first <= 1'b1;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          event_kind    <= EV_NONE;
          out_proc_id   <= '0;
          out_thread_id <= '0;
          event_time    <= '0;
          state         <= S_OUT;
          unique case (req)
            REQ_ENQUEUE: begin
              if (push_full) begin
                event_kind <= EV_ERR;
              end else begin
                qtail[push_q]  <= tail_inc;
                qcount[push_q] <= qcount[push_q] + 1'b1;
              end
            end
            REQ_DISPATCH: begin
              last_queue <= sel_q;
              if (qcount[sel_q] == '0) begin
                event_kind <= EV_ERR;
              end else begin
                qhead[sel_q]  <= head_inc;
                qcount[sel_q] <= qcount[sel_q] - 1'b1;
                state         <= S_RDWT;
              end
            end
            REQ_BLOCK: begin
              if (!running_valid || pool_n == BC_W'(BLOCKED_DEPTH)) begin
                event_kind <= EV_ERR;
              end else begin
                pool_n        <= pool_n + 1'b1;
                event_kind    <= EV_IO;
                out_proc_id   <= pid;
                out_thread_id <= tid;
                event_time    <= io;
              end
            end
            REQ_READY: begin
              state <= S_SCAN;
              idx   <= idx + 1'b1;  // read of entry 0 launched this cycle
            end
            REQ_QUERY: begin
              last_queue <= sel_q;
              if (qcount[sel_q] != '0)  event_kind <= EV_DUE;
              else if (pool_n == '0)    event_kind <= EV_DONE;
              else begin
                event_kind <= EV_DUE;
                state      <= S_SCAN;
                idx        <= idx + 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_RDWT: begin
          // ready store word read now available
          out_proc_id   <= rs_rdata[ENTRY_W-1:ID_W+CLASS_W];
          out_thread_id <= rs_rdata[ID_W+CLASS_W-1:CLASS_W];
          if (running_valid && running_entry[ENTRY_W-1:ID_W+CLASS_W] ==
              rs_rdata[ENTRY_W-1:ID_W+CLASS_W]) begin
            event_kind <= EV_TSW;
            event_time <= tsw_ovh;
          end else begin
            event_kind <= EV_PSW;
            event_time <= psw_ovh;
          end
          running_entry <= rs_rdata;
          running_valid <= 1'b1;
          state         <= S_OUT;
        end
        S_SCAN: begin
          // bp_rdata holds entry idx-1
          if (req == REQ_READY) begin
            if (BC_W'(idx - 1'b1) >= pool_n) begin
              state <= S_OUT;  // miss
            end else if (scan_hit) begin
              if (push_full) begin
                event_kind <= EV_ERR;
                state      <= S_OUT;
              end else begin
                qtail[push_q]  <= tail_inc;
                qcount[push_q] <= qcount[push_q] + 1'b1;
                idx            <= idx - 1'b1;
                state          <= S_SHIFT;
              end
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            if (scan_first || bp_rdata[TIME_W-1:0] < best) begin
              best <= bp_rdata[TIME_W-1:0];
            end
            scan_first <= 1'b0;
            if (idx >= pool_n) begin
              event_time <= (scan_first || bp_rdata[TIME_W-1:0] < best) ?
                            bp_rdata[TIME_W-1:0] : best;
              state <= S_OUT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_SHIFT: begin
          // close the gap at idx: copy idx+1 down, drop the tail
          if (BC_W'(idx + 1'b1) >= pool_n) begin
            pool_n <= pool_n - 1'b1;
            state  <= S_OUT;
          end else begin
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          idx   <= idx + 1'b1;
          state <= S_SHIFT;
        end
        S_OUT: begin
          queue_index <= last_queue;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> verif/tb_strict_priority_ready_queue_dispatcher.sv
// Self-checking testbench for strict_priority_ready_queue_dispatcher: directed table then
// random request mix, checked word by word against an in-bench scheduler predictor.
// Depends on spqd_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

module tb_strict_priority_ready_queue_dispatcher;
  import spqd_pkg::*;

  localparam int QDEPTH = 16;
  localparam int PDEPTH = 16;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  pid;
    logic [9:0]  tid;
    logic [15:0] tval;
    logic [1:0]  qidx;
  } event_word_t;

  typedef struct packed {
    logic [2:0]  req;
    logic [9:0]  pid;
    logic [9:0]  tid;
    logic [1:0]  cls;
    logic [15:0] io;
    logic        has_gold;
    event_word_t gold;
  } req_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0]  req_type = '0;
  logic [9:0]  proc_id = '0;
  logic [9:0]  thread_id = '0;
  logic [1:0]  prio_class = '0;
  logic [15:0] io_time = '0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        done;
  logic [2:0]  event_kind;
  logic [9:0]  out_proc_id;
  logic [9:0]  out_thread_id;
  logic [15:0] event_time;
  logic [1:0]  queue_index;

  strict_priority_ready_queue_dispatcher #(
    .QUEUE_DEPTH(QDEPTH), .BLOCKED_DEPTH(PDEPTH)
  ) u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow scheduler state.
  logic [15:0] tsw_cost, psw_cost;
  entry_t      ready_q [NUM_Q][$];
  entry_t      run_entry;
  logic        run_valid;
  entry_t      pool_entry [$];
  logic [15:0] pool_io [$];
  logic [1:0]  sel_q;
  event_word_t expected_events [$];
  int          mismatches = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic logic [1:0] pick_class();
    for (int q = 0; q < 3; q++)
      if (ready_q[q].size() != 0) return q[1:0];
    return 2'd3;
  endfunction

  // Advance the shadow state by one request and return the word it produces.
  function automatic event_word_t schedule(input req_row_t r);
    event_word_t ev;
    entry_t      e;
    logic [15:0] best;
    ev = '0;
    case (r.req)
      REQ_ENQUEUE: begin
        if (ready_q[r.cls].size() >= QDEPTH) ev.kind = EV_ERR;
        else ready_q[r.cls].insert(ready_q[r.cls].size(), {r.pid, r.tid, r.cls});
      end
      REQ_DISPATCH: begin
        sel_q = pick_class();
        if (ready_q[sel_q].size() == 0) ev.kind = EV_ERR;
        else begin
          e = ready_q[sel_q].pop_front();
          ev.pid = e[21:12];
          ev.tid = e[11:2];
          if (run_valid && run_entry[21:12] == ev.pid) begin
            ev.kind = EV_TSW;
            ev.tval = tsw_cost;
          end else begin
            ev.kind = EV_PSW;
            ev.tval = psw_cost;
          end
          run_entry = e;
          run_valid = 1'b1;
        end
      end
      REQ_BLOCK: begin
        if (!run_valid || pool_entry.size() >= PDEPTH) ev.kind = EV_ERR;
        else begin
          pool_entry.insert(pool_entry.size(), run_entry);
          pool_io.insert(pool_io.size(), r.io);
          ev.kind = EV_IO;
          ev.pid = r.pid;
          ev.tid = r.tid;
          ev.tval = r.io;
        end
      end
      REQ_READY: begin
        for (int i = 0; i < pool_entry.size(); i++) begin
          if (pool_entry[i][21:12] == r.pid && pool_entry[i][11:2] == r.tid) begin
            e = pool_entry[i];
            if (ready_q[e[1:0]].size() >= QDEPTH) ev.kind = EV_ERR;
            else begin
              ready_q[e[1:0]].insert(ready_q[e[1:0]].size(), e);
              pool_entry.delete(i);
              pool_io.delete(i);
            end
            break;
          end
        end
      end
      REQ_QUERY: begin
        sel_q = pick_class();
        if (ready_q[sel_q].size() != 0) ev.kind = EV_DUE;
        else if (pool_entry.size() == 0) ev.kind = EV_DONE;
        else begin
          best = pool_io[0];
          foreach (pool_io[i]) if (pool_io[i] < best) best = pool_io[i];
          ev.kind = EV_DUE;
          ev.tval = best;
        end
      end
      default: ;
    endcase
    ev.qidx = sel_q;
    return ev;
  endfunction

  // Check each word the cycle it is strobed.
  always @(posedge clk) begin
    event_word_t want;
    if (!rst && done) begin
      if (expected_events.size() == 0) report("word with nothing outstanding");
      else begin
        want = expected_events.pop_front();
        if (event_kind !== want.kind)
          report($sformatf("event_kind %0d want %0d", event_kind, want.kind));
        if (out_proc_id !== want.pid)
          report($sformatf("out_proc_id %0d want %0d", out_proc_id, want.pid));
        if (out_thread_id !== want.tid)
          report($sformatf("out_thread_id %0d want %0d", out_thread_id, want.tid));
        if (event_time !== want.tval)
          report($sformatf("event_time %0d want %0d", event_time, want.tval));
        if (queue_index !== want.qidx)
          report($sformatf("queue_index %0d want %0d", queue_index, want.qidx));
      end
    end
  end

  // Issue one request: idle a random gap, hold start until the handshake lands.
  // With no gap, start stays high into the next request while the block is busy.
  task automatic issue(input req_row_t r);
    event_word_t ev;
    int          gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_type   <= r.req;
    proc_id    <= r.pid;
    thread_id  <= r.tid;
    prio_class <= r.cls;
    io_time    <= r.io;
    start      <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    ev = schedule(r);
    if (r.has_gold && ev !== r.gold)
      report($sformatf("predictor disagrees with table row req %0d", r.req));
    expected_events.insert(expected_events.size(), r.has_gold ? r.gold : ev);
  endtask

  // Drain outstanding words, let the pool scan settle, then write a register.
  task automatic write_cost(input logic [0:0] idx, input logic [15:0] val);
    start <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TSW) tsw_cost = val;
    else psw_cost = val;
  endtask

  function automatic req_row_t mk(input logic [2:0] rq, input logic [9:0] p,
                                  input logic [9:0] t, input logic [1:0] c,
                                  input logic [15:0] io);
    req_row_t r;
    r = '0;
    r.req = rq; r.pid = p; r.tid = t; r.cls = c; r.io = io;
    return r;
  endfunction

  function automatic req_row_t gold(input req_row_t r, input logic [2:0] k,
                                    input logic [15:0] tv, input logic [1:0] q);
    r.has_gold = 1'b1;
    r.gold = '{kind: k, pid: '0, tid: '0, tval: tv, qidx: q};
    return r;
  endfunction

  req_row_t    directed [$];
  req_row_t    r;
  logic [9:0]  pid_pool [4];
  int          sent;

  // Append one row to the directed table.
  task automatic add_row(input req_row_t row);
    directed.insert(directed.size(), row);
  endtask

  initial begin
    tsw_cost = '0; psw_cost = '0;
    run_entry = '0; run_valid = 1'b0; sel_q = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, extremes of every field, every request kind.
    add_row(gold(mk(REQ_QUERY, 0, 0, 0, 0), EV_DONE, 0, 3));
    add_row(gold(mk(REQ_DISPATCH, 0, 0, 0, 0), EV_ERR, 0, 3));
    add_row(gold(mk(REQ_BLOCK, 5, 6, 0, 100), EV_ERR, 0, 3));
    add_row(gold(mk(REQ_READY, 1, 1, 0, 0), EV_NONE, 0, 3));
    add_row(gold(mk(3'd5, 10'h3FF, 10'h3FF, 3, 16'hFFFF), EV_NONE, 0, 3));
    add_row(gold(mk(3'd6, 0, 0, 0, 0), EV_NONE, 0, 3));
    add_row(gold(mk(3'd7, 0, 0, 0, 0), EV_NONE, 0, 3));
    add_row(mk(REQ_ENQUEUE, 10'h3FF, 10'h3FF, 3, 16'hFFFF));
    add_row(mk(REQ_ENQUEUE, 0, 0, 0, 0));
    add_row(mk(REQ_ENQUEUE, 0, 1, 1, 0));
    add_row(mk(REQ_ENQUEUE, 7, 2, 2, 0));
    add_row(mk(REQ_QUERY, 0, 0, 0, 0));
    add_row(mk(REQ_DISPATCH, 0, 0, 0, 0));   // first dispatch: process switch
    add_row(mk(REQ_DISPATCH, 0, 0, 0, 0));   // same pid: thread switch
    add_row(mk(REQ_BLOCK, 10'h3FF, 10'h3FF, 0, 16'hFFFF));
    add_row(mk(REQ_BLOCK, 0, 1, 0, 0));      // repeated block
    add_row(mk(REQ_DISPATCH, 0, 0, 0, 0));
    add_row(mk(REQ_DISPATCH, 0, 0, 0, 0));
    add_row(mk(REQ_QUERY, 0, 0, 0, 0));      // least I/O time
    add_row(mk(REQ_READY, 0, 1, 0, 0));      // first match taken
    add_row(mk(REQ_READY, 0, 1, 0, 0));
    add_row(mk(REQ_READY, 0, 1, 0, 0));      // miss
    add_row(mk(REQ_DISPATCH, 0, 0, 0, 0));
    foreach (directed[i]) issue(directed[i]);

    write_cost(CFG_TSW, 16'hFFFF);
    write_cost(CFG_PSW, 16'h0000);
    // Fill one class to overflow it, then drain it.
    for (int i = 0; i < QDEPTH + 2; i++) issue(mk(REQ_ENQUEUE, 3, i[9:0], 2, 0));
    for (int i = 0; i < QDEPTH + 2; i++) issue(mk(REQ_DISPATCH, 0, 0, 0, 0));
    write_cost(CFG_TSW, 16'h0001);
    write_cost(CFG_PSW, 16'hFFFF);

    // Random: mostly meaningful requests on a small set of ids so that ready hits.
    sent = 0;
    while (sent < 1050) begin
      if (sent % 300 == 299) begin
        write_cost(CFG_TSW, 16'($urandom));
        write_cost(CFG_PSW, 16'($urandom));
      end
      foreach (pid_pool[i]) if (sent % 200 == 0) pid_pool[i] = 10'($urandom);
      r = mk('0, pid_pool[$urandom_range(0, 3)], 10'($urandom_range(0, 5)),
             2'($urandom), 16'($urandom));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: r.req = REQ_ENQUEUE;
        6, 7, 8, 9: r.req = REQ_DISPATCH;
        10, 11, 12: r.req = REQ_BLOCK;
        13, 14, 15: begin
          r.req = REQ_READY;
          if (pool_entry.size() != 0 && $urandom_range(0, 3) != 0) begin
            r.pid = pool_entry[$urandom_range(0, pool_entry.size() - 1)][21:12];
            r.tid = pool_entry[$urandom_range(0, pool_entry.size() - 1)][11:2];
            foreach (pool_entry[i]) if ($urandom_range(0, 1)) begin
              r.pid = pool_entry[i][21:12];
              r.tid = pool_entry[i][11:2];
            end
          end
        end
        16, 17: r.req = REQ_QUERY;
        18: begin
          r.req = 3'($urandom_range(5, 7));
          r.pid = 10'($urandom);
          r.tid = 10'($urandom);
        end
        default: begin
          r.req = 3'($urandom_range(0, 4));
          r.pid = 10'($urandom);
          r.tid = 10'($urandom);
        end
      endcase
      issue(r);
      sent++;
    end

    start <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("[strict_priority_ready_queue_dispatcher] OK");
    end else begin
      $display("[strict_priority_ready_queue_dispatcher] ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legitimate run.
  initial begin
    #4000000;
    $display("[strict_priority_ready_queue_dispatcher] ERROR");
    $finish;
  end
endmodule
